FILE: hdl/amps_pkg.sv
// Shared codes, sizes and defaults for the adaptive message period scheduler.
// No dependencies.
package amps_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned TickBits   = 32;

  localparam logic [1:0] OpSend  = 2'd0;
  localparam logic [1:0] OpAck   = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;
  localparam logic [1:0] OpQuery = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StDup     = 2'd1;
  localparam logic [1:0] StUnknown = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic [1:0] PmWait  = 2'd0;
  localparam logic [1:0] PmSend  = 2'd1;
  localparam logic [1:0] PmEnded = 2'd2;

  localparam logic [2:0] RegMaxOut  = 3'd0;
  localparam logic [2:0] RegPhase   = 3'd1;
  localparam logic [2:0] RegInitRtt = 3'd2;
  localparam logic [2:0] RegMargin  = 3'd3;
  localparam logic [2:0] RegRunLen  = 3'd4;

  localparam logic [31:0] InitRttReset = 32'd800;
  localparam logic [15:0] MarginReset  = 16'd10;

endpackage

FILE: hdl/amps_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module amps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hdl/amps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter.
module amps_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         busy_o,
  output logic [W-1:0] quo_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] quo_q, quo_d, rem_q, rem_d, den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[W-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CW'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
endmodule

FILE: hdl/adaptive_message_period_scheduler.sv
// Adaptive message period scheduler: table of outstanding messages in RAM.
// A send, ack or tick walks the table one entry a cycle; an ack or tick that
// changes the estimate then recomputes the period, by the serial divider while
// fewer than max_out entries are outstanding. A query skips the walk. One item at a time.
// Reset clears valid bits and loads estimates from the register defaults.
// Depends on amps_pkg, amps_ram, amps_div.
module adaptive_message_period_scheduler #(
  parameter int unsigned TABLE_DEPTH = amps_pkg::TableDepth,
  parameter int unsigned TICK_BITS   = amps_pkg::TickBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic [15:0] msg_id_i,
  input  logic [31:0] now_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status_o,
  output logic [1:0]  permit_o,
  output logic        deadline_missed_o,
  output logic [31:0] period_o,
  output logic [31:0] rtt_estimate_o,
  output logic [31:0] relative_deadline_o,
  output logic [4:0]  outstanding_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = 16 + 2 * TICK_BITS;
  localparam logic [TICK_BITS-1:0] TickMax = '1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_ACT   = 6'b000100,
    S_DIVGO = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]            max_out_q;
  logic [31:0]           phase_q;
  logic [15:0]           margin_q;
  logic [7:0]            run_len_q;
  logic [TICK_BITS-1:0]  rtt_q, rtt_d, rel_q, rel_d, per_q, per_d, last_q, last_d;
  logic [TICK_BITS-1:0]  avg_q, avg_d;
  logic [7:0]            better_q, better_d;
  logic                  firstq_q, firstq_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]         count_q, count_d;

  logic [1:0]            op_q;
  logic [15:0]           id_q;
  logic [TICK_BITS-1:0]  now_q;
  logic [CW:0]           idx_q, idx_d;
  logic                  hit_q, hit_d, free_q, free_d, miss_q, miss_d;
  logic [AW-1:0]         hslot_q, hslot_d, fslot_q, fslot_d;
  logic [TICK_BITS-1:0]  hsent_q, hsent_d, habs_q, habs_d;

  logic [1:0]  status_q, status_d, permit_q, permit_d;
  logic        missed_out_q, missed_out_d;
  logic        ovalid_q, ovalid_d;

  // result register, held while the result side stalls
  logic                 out_load;
  logic [1:0]           res_status_q, res_permit_q;
  logic                 res_missed_q;
  logic [TICK_BITS-1:0] res_per_q, res_rtt_q, res_rel_q;
  logic [CW-1:0]        res_count_q;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  amps_ram #(.Width(EW), .Depth(TABLE_DEPTH)) u_tab (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [15:0]          r_id;
  logic [TICK_BITS-1:0] r_sent, r_abs;
  assign {r_id, r_sent, r_abs} = rdata;

  // divider
  logic                 div_start, div_busy;
  logic [TICK_BITS-1:0] div_den, div_quo;
  amps_div #(.W(TICK_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(rel_q), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  function automatic logic [TICK_BITS-1:0] sat_add(input logic [TICK_BITS-1:0] a,
                                                    input logic [TICK_BITS-1:0] b);
    logic [TICK_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_BITS] ? TickMax : s[TICK_BITS-1:0];
  endfunction

  logic [TICK_BITS-1:0] margin_w, cfg_rtt_w, meas, avg_tmp, avg_new;
  logic [TICK_BITS:0]   qsum;
  logic                 need_div, k_full, scan_cmp, room;
  logic [7:0]           bc_inc;
  logic [AW-1:0]        scan_slot;

  assign margin_w  = TICK_BITS'(margin_q);
  assign cfg_rtt_w = TICK_BITS'(cfg_data_i);
  assign k_full    = 9'(count_q) >= 9'(max_out_q);
  assign div_den   = TICK_BITS'(9'(max_out_q) - 9'(count_q));
  assign scan_slot = idx_q[AW-1:0] - AW'(1);
  assign raddr     = idx_q[AW-1:0];
  assign out_load  = (state_q == S_OUT) && (!ovalid_q || !out_stall);

  always_comb begin
    state_d = state_q;
    rtt_d = rtt_q; rel_d = rel_q; per_d = per_q; last_d = last_q;
    avg_d = avg_q; better_d = better_q; firstq_d = firstq_q;
    valid_d = valid_q; count_d = count_q;
    idx_d = idx_q; hit_d = hit_q; free_d = free_q; miss_d = miss_q;
    hslot_d = hslot_q; fslot_d = fslot_q; hsent_d = hsent_q; habs_d = habs_q;
    status_d = status_q; permit_d = permit_q; missed_out_d = missed_out_q;
    ovalid_d = ovalid_q;
    we = 1'b0; waddr = fslot_q;
    wdata = {id_q, now_q, TICK_BITS'(now_q + rel_q)};
    div_start = 1'b0; need_div = 1'b0;
    meas = TICK_BITS'(now_q - hsent_q);
    avg_tmp = '0; avg_new = '0; bc_inc = better_q + 8'd1;
    qsum = {1'b0, now_q} + {1'b0, rel_q};
    room = (9'(count_q) + 9'd1) < 9'(max_out_q);
    scan_cmp = 1'b0;
    if (ovalid_q && !out_stall) ovalid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        idx_d = '0; hit_d = 1'b0; free_d = 1'b0; miss_d = 1'b0;
        if (in_valid && !in_stall) begin
          state_d = (op_i == amps_pkg::OpQuery) ? S_ACT : S_SCAN;
        end
      end
      S_SCAN: begin
        // rdata holds entry idx_q-1
        if (idx_q != '0) begin
          scan_cmp = valid_q[scan_slot];
          if (scan_cmp && r_id == id_q && !hit_d) begin
            hit_d = 1'b1; hslot_d = scan_slot; hsent_d = r_sent; habs_d = r_abs;
          end
          if (!scan_cmp && !free_d) begin
            free_d = 1'b1; fslot_d = scan_slot;
          end
          if (scan_cmp && r_abs == now_q) miss_d = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == (CW+1)'(TABLE_DEPTH)) state_d = S_ACT;
      end
      S_ACT: begin
        status_d = amps_pkg::StOk; permit_d = amps_pkg::PmWait; missed_out_d = 1'b0;
        state_d = S_OUT;
        unique case (op_q)
          amps_pkg::OpSend: begin
            if (hit_q) status_d = amps_pkg::StDup;
            else if (!free_q) status_d = amps_pkg::StFull;
            else begin
              we = 1'b1;
              valid_d[fslot_q] = 1'b1;
              count_d = count_q + 1'b1;
              last_d = now_q;
            end
          end
          amps_pkg::OpAck: begin
            if (!hit_q || habs_q == hsent_q) status_d = amps_pkg::StUnknown;
            else begin
              valid_d[hslot_q] = 1'b0;
              count_d = count_q - 1'b1;
              if (habs_q > now_q) begin
                if (meas < rtt_q) begin
                  if (TICK_BITS'(rtt_q - meas) > margin_w) begin
                    better_d = bc_inc;
                    avg_tmp = (avg_q <= TICK_BITS'(1)) ? meas : avg_q;
                    avg_new = (meas >> 1) + (avg_tmp >> 1) +
                              TICK_BITS'(meas[0] & avg_tmp[0]);
                    avg_d = avg_new;
                    if (bc_inc == run_len_q) begin
                      rtt_d = sat_add(avg_new, margin_w);
                      rel_d = sat_add(avg_new, margin_w);
                      avg_d = '0; better_d = '0; need_div = 1'b1;
                    end
                  end else begin
                    better_d = '0; avg_d = '0;
                  end
                end
              end else if (meas > rel_q) begin
                rtt_d = meas; rel_d = sat_add(meas, margin_w); need_div = 1'b1;
              end
            end
          end
          amps_pkg::OpTick: begin
            missed_out_d = miss_q;
            if (miss_q) begin
              rtt_d = sat_add(rtt_q, margin_w);
              rel_d = sat_add(sat_add(rtt_q, margin_w), margin_w);
              need_div = 1'b1;
            end
          end
          default: begin
            if (firstq_q) begin
              firstq_d = 1'b0; permit_d = amps_pkg::PmSend;
            end else if (qsum[TICK_BITS] || qsum[TICK_BITS-1:0] >= TICK_BITS'(phase_q)) begin
              permit_d = amps_pkg::PmEnded;
            end else if (room && TICK_BITS'(now_q - last_q) >= per_q) begin
              permit_d = amps_pkg::PmSend;
            end
          end
        endcase
        if (need_div) state_d = S_DIVGO;
      end
      S_DIVGO: begin
        // count and rel are settled now
        if (k_full) begin
          per_d = rtt_q; state_d = S_OUT;
        end else begin
          div_start = 1'b1; state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          per_d = div_quo; state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          ovalid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid && cfg_ready && cfg_index_i == amps_pkg::RegInitRtt) begin
      rtt_d = cfg_rtt_w; avg_d = cfg_rtt_w; rel_d = sat_add(cfg_rtt_w, margin_w);
    end
  end

  assign in_stall  = state_q != S_IDLE;
  assign cfg_ready = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      max_out_q <= '0;
      phase_q   <= '1;
      margin_q  <= amps_pkg::MarginReset;
      run_len_q <= 8'd5;
      rtt_q     <= TICK_BITS'(amps_pkg::InitRttReset);
      avg_q     <= TICK_BITS'(amps_pkg::InitRttReset);
      rel_q     <= TICK_BITS'(amps_pkg::InitRttReset) + TICK_BITS'(amps_pkg::MarginReset);
      per_q     <= '0;
      last_q    <= '0;
      better_q  <= '0;
      firstq_q  <= 1'b1;
      valid_q   <= '0;
      count_q   <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rtt_q    <= rtt_d;
      avg_q    <= avg_d;
      rel_q    <= rel_d;
      per_q    <= per_d;
      last_q   <= last_d;
      better_q <= better_d;
      firstq_q <= firstq_d;
      valid_q  <= valid_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_i)
          amps_pkg::RegMaxOut: max_out_q <= cfg_data_i[7:0];
          amps_pkg::RegPhase:  phase_q   <= cfg_data_i;
          amps_pkg::RegMargin: margin_q  <= cfg_data_i[15:0];
          amps_pkg::RegRunLen: run_len_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      op_q  <= op_i;
      id_q  <= msg_id_i;
      now_q <= TICK_BITS'(now_i);
    end
    idx_q <= idx_d; hit_q <= hit_d; free_q <= free_d; miss_q <= miss_d;
    hslot_q <= hslot_d; fslot_q <= fslot_d; hsent_q <= hsent_d; habs_q <= habs_d;
    status_q <= status_d; permit_q <= permit_d; missed_out_q <= missed_out_d;
    if (out_load) begin
      res_status_q <= status_q;
      res_permit_q <= permit_q;
      res_missed_q <= missed_out_q;
      res_per_q    <= per_q;
      res_rtt_q    <= rtt_q;
      res_rel_q    <= rel_q;
      res_count_q  <= count_q;
    end
  end

  assign out_valid           = ovalid_q;
  assign status_o            = res_status_q;
  assign permit_o            = res_permit_q;
  assign deadline_missed_o   = res_missed_q;
  assign period_o            = 32'(res_per_q);
  assign rtt_estimate_o      = 32'(res_rtt_q);
  assign relative_deadline_o = 32'(res_rel_q);
  assign outstanding_o       = 5'(res_count_q);
endmodule

FILE: tb/amps_checker.sv
// Checker for the adaptive message period scheduler: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on amps_pkg.
module amps_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic [15:0] msg_id_i,
  input  logic [31:0] now_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status_i,
  input  logic [1:0]  permit_i,
  input  logic        deadline_missed_i,
  input  logic [31:0] period_i,
  input  logic [31:0] rtt_estimate_i,
  input  logic [31:0] relative_deadline_i,
  input  logic [4:0]  outstanding_i,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  permit;
    logic        missed;
    logic [31:0] period;
    logic [31:0] rtt;
    logic [31:0] rel;
    logic [4:0]  outst;
  } sched_result_t;

  sched_result_t sched_expected_q[$];
  int err_count;

  logic [7:0]  kmax;
  logic [31:0] phase_end;
  logic [31:0] init_rtt;
  logic [15:0] margin;
  logic [7:0]  run_len;

  logic        ent_v[amps_pkg::TableDepth];
  logic [15:0] ent_id[amps_pkg::TableDepth];
  logic [31:0] ent_sent[amps_pkg::TableDepth];
  logic [31:0] ent_dl[amps_pkg::TableDepth];

  logic [31:0] rtt_est, rel_dl, period_cur, last_send, avg_rtt;
  logic [7:0]  better_cnt;
  logic        first_query;

  assign err_count_o = err_count;
  assign pending_o   = sched_expected_q.size();

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < amps_pkg::TableDepth; i++) if (ent_v[i]) n++;
    return n;
  endfunction

  function automatic int find_slot(input logic [15:0] id);
    for (int i = 0; i < amps_pkg::TableDepth; i++)
      if (ent_v[i] && ent_id[i] == id) return i;
    return -1;
  endfunction

  task automatic refresh_period();
    int k;
    k = live_count();
    if (k >= kmax) period_cur = rtt_est;
    else period_cur = rel_dl / (32'(kmax) - 32'(k));
  endtask

  task automatic load_estimate();
    rtt_est = init_rtt;
    avg_rtt = init_rtt;
    rel_dl  = sat_add(init_rtt, 32'(margin));
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [15:0] id,
                              input logic [31:0] now);
    sched_result_t r;
    int slot, k;
    logic [31:0] meas;
    logic [32:0] sum;
    logic in_cycle, room, spaced;
    r = '0;
    if (op == amps_pkg::OpSend) begin
      if (find_slot(id) >= 0) begin
        r.status = amps_pkg::StDup;
      end else begin
        slot = -1;
        for (int i = 0; i < amps_pkg::TableDepth; i++) if (!ent_v[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = amps_pkg::StFull;
        end else begin
          ent_v[slot]    = 1'b1;
          ent_id[slot]   = id;
          ent_sent[slot] = now;
          ent_dl[slot]   = now + rel_dl;
          last_send      = now;
        end
      end
    end else if (op == amps_pkg::OpAck) begin
      slot = find_slot(id);
      if (slot < 0 || ent_dl[slot] - ent_sent[slot] == 32'd0) begin
        r.status = amps_pkg::StUnknown;
      end else begin
        meas = now - ent_sent[slot];
        ent_v[slot] = 1'b0;
        if (ent_dl[slot] > now) begin
          if (meas < rtt_est) begin
            if (rtt_est - meas > 32'(margin)) begin
              better_cnt++;
              if (avg_rtt <= 32'd1) avg_rtt = meas;
              avg_rtt = (meas >> 1) + (avg_rtt >> 1) + 32'(meas[0] & avg_rtt[0]);
              if (better_cnt == run_len) begin
                rtt_est = sat_add(avg_rtt, 32'(margin));
                rel_dl  = rtt_est;
                refresh_period();
                avg_rtt    = '0;
                better_cnt = '0;
              end
            end else begin
              better_cnt = '0;
              avg_rtt    = '0;
            end
          end
        end else if (meas > rel_dl) begin
          rtt_est = meas;
          rel_dl  = sat_add(meas, 32'(margin));
          refresh_period();
        end
      end
    end else if (op == amps_pkg::OpTick) begin
      for (int i = 0; i < amps_pkg::TableDepth; i++)
        if (ent_v[i] && ent_dl[i] == now) r.missed = 1'b1;
      if (r.missed) begin
        rtt_est = sat_add(rtt_est, 32'(margin));
        rel_dl  = sat_add(rtt_est, 32'(margin));
        refresh_period();
      end
    end else begin
      if (first_query) begin
        first_query = 1'b0;
        r.permit = amps_pkg::PmSend;
      end else begin
        k = live_count();
        room = (k + 1) < int'(kmax);
        sum = {1'b0, now} + {1'b0, rel_dl};
        in_cycle = !sum[32] && (sum[31:0] < phase_end);
        spaced = (now - last_send) >= period_cur;
        if (!in_cycle) r.permit = amps_pkg::PmEnded;
        else r.permit = (room && spaced) ? amps_pkg::PmSend : amps_pkg::PmWait;
      end
    end
    r.period = period_cur;
    r.rtt    = rtt_est;
    r.rel    = rel_dl;
    r.outst  = 5'(live_count());
    sched_expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want, got;
    if (!rst_ni) begin
      kmax      = '0;
      phase_end = 32'hFFFF_FFFF;
      init_rtt  = amps_pkg::InitRttReset;
      margin    = amps_pkg::MarginReset;
      run_len   = 8'd5;
      for (int i = 0; i < amps_pkg::TableDepth; i++) ent_v[i] = 1'b0;
      load_estimate();
      period_cur  = '0;
      last_send   = '0;
      better_cnt  = '0;
      first_query = 1'b1;
      sched_expected_q.delete();
      err_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status_i, permit_i, deadline_missed_i, period_i, rtt_estimate_i,
                relative_deadline_i, outstanding_i};
        if (sched_expected_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("result with no item pending: %h", got);
        end else begin
          want = sched_expected_q.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display({"mismatch st %0d/%0d pm %0d/%0d miss %0d/%0d per %0d/%0d",
                        " rtt %0d/%0d rel %0d/%0d out %0d/%0d (exp/act)"},
                       want.status, got.status, want.permit, got.permit,
                       want.missed, got.missed, want.period, got.period,
                       want.rtt, got.rtt, want.rel, got.rel,
                       want.outst, got.outst);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          amps_pkg::RegMaxOut:  kmax = cfg_data_i[7:0];
          amps_pkg::RegPhase:   phase_end = cfg_data_i;
          amps_pkg::RegInitRtt: begin
            init_rtt = cfg_data_i;
            load_estimate();
          end
          amps_pkg::RegMargin:  margin = cfg_data_i[15:0];
          amps_pkg::RegRunLen:  run_len = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_item(op_i, msg_id_i, now_i);
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the scheduler testbench: clock, reset, register phases and item stimulus.
// Depends on amps_pkg, amps_checker and the scheduler RTL.
module testbench;

  localparam int CycleLimit = 1000000;
  localparam int NumPhases  = 6;

  localparam logic [7:0]  KmaxSet[NumPhases]   = '{8'd4, 8'd0, 8'd255, 8'd17, 8'd1, 8'd8};
  localparam logic [31:0] InitSet[NumPhases]   = '{32'd800, 32'd0, 32'hFFFF_FFFF, 32'd1,
                                                   32'd2, 32'd300};
  localparam logic [15:0] MarginSet[NumPhases] = '{16'd10, 16'd0, 16'hFFFF, 16'd0,
                                                   16'd3, 16'd20};
  localparam logic [7:0]  RunSet[NumPhases]    = '{8'd2, 8'd1, 8'd255, 8'd3, 8'd1, 8'd5};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op_i = amps_pkg::OpQuery;
  logic [15:0] msg_id_i = '0;
  logic [31:0] now_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status_o, permit_o;
  logic        deadline_missed_o;
  logic [31:0] period_o, rtt_estimate_o, relative_deadline_o;
  logic [4:0]  outstanding_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index_i = amps_pkg::RegMaxOut;
  logic [31:0] cfg_data_i = '0;
  int          err_count, pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [31:0] rel_seen = 32'd810;
  logic [31:0] cur_now = 32'd1000;
  logic [15:0] live_id[$];
  logic [31:0] live_t[$];
  logic [31:0] live_dl[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  adaptive_message_period_scheduler i_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i, .msg_id_i, .now_i,
    .out_valid, .out_stall, .status_o, .permit_o, .deadline_missed_o,
    .period_o, .rtt_estimate_o, .relative_deadline_o, .outstanding_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  amps_checker i_checker (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i, .msg_id_i, .now_i,
    .out_valid, .out_stall, .status_i(status_o), .permit_i(permit_o),
    .deadline_missed_i(deadline_missed_o), .period_i(period_o),
    .rtt_estimate_i(rtt_estimate_o), .relative_deadline_i(relative_deadline_o),
    .outstanding_i(outstanding_o), .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) if (out_valid && !out_stall) rel_seen <= relative_deadline_o;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk_i) begin
    int run;
    if (rst_ni) begin
      if (run > 0) begin
        run--;
      end else begin
        run = gap_len();
      end
      out_stall <= (run > 0);
    end
  end

  // valid stays high between back-to-back items
  task automatic put_item(input logic [1:0] op, input logic [15:0] id, input logic [31:0] now);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    op_i     <= op;
    msg_id_i <= id;
    now_i    <= now;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_item();
    int r, j;
    logic [31:0] t;
    logic [15:0] id;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      put_item(2'($urandom), 16'($urandom), $urandom);
    end else if (r < 40) begin
      if ($urandom_range(0, 19) == 0) cur_now = $urandom;
      else cur_now += $urandom_range(1, 50);
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
      put_item(amps_pkg::OpSend, id, cur_now);
      if (live_id.size() < 24) begin
        live_id.push_back(id);
        live_t.push_back(cur_now);
        live_dl.push_back(cur_now + rel_seen);
      end
    end else if (r < 72) begin
      if (live_id.size() == 0 || $urandom_range(0, 9) == 0) begin
        put_item(amps_pkg::OpAck, 16'($urandom_range(0, 23)), cur_now);
      end else begin
        j = $urandom_range(0, live_id.size() - 1);
        case ($urandom_range(0, 3))
          0:       t = live_t[j] + $urandom_range(0, 200);
          1:       t = live_t[j] + $urandom_range(0, 2000);
          2:       t = live_dl[j] + $urandom_range(0, 3000);
          default: t = live_t[j] + $urandom;
        endcase
        put_item(amps_pkg::OpAck, live_id[j], t);
        live_id.delete(j);
        live_t.delete(j);
        live_dl.delete(j);
      end
    end else if (r < 86) begin
      if (live_id.size() != 0 && $urandom_range(0, 1) == 1)
        put_item(amps_pkg::OpTick, 16'($urandom),
                 live_dl[$urandom_range(0, live_dl.size() - 1)]);
      else
        put_item(amps_pkg::OpTick, 16'($urandom), cur_now + $urandom_range(0, 1000));
    end else begin
      put_item(amps_pkg::OpQuery, 16'($urandom), cur_now + $urandom_range(0, 2000));
    end
  endtask

  task automatic directed_items();
    put_item(amps_pkg::OpQuery, 16'h0000, 32'd0);
    put_item(amps_pkg::OpQuery, 16'hFFFF, 32'hFFFF_FFFF);
    put_item(amps_pkg::OpSend, 16'h0000, 32'd100);
    put_item(amps_pkg::OpSend, 16'hFFFF, 32'd110);
    put_item(amps_pkg::OpSend, 16'h0000, 32'd120);
    put_item(amps_pkg::OpAck, 16'h0007, 32'd130);
    put_item(amps_pkg::OpAck, 16'h0000, 32'd150);
    put_item(amps_pkg::OpTick, 16'h0000, 32'd920);
    put_item(amps_pkg::OpQuery, 16'h0000, 32'd900);
    put_item(amps_pkg::OpAck, 16'hFFFF, 32'd5000);
    for (int i = 1; i <= 17; i++)
      put_item(amps_pkg::OpSend, 16'(i), 32'hFFFF_FFF0 + 32'(i));
    put_item(amps_pkg::OpQuery, 16'h0000, 32'd10);
    put_item(amps_pkg::OpTick, 16'h0000, 32'd0);
    put_item(amps_pkg::OpTick, 16'h0000, 32'hFFFF_FFFF);
    for (int i = 1; i <= 17; i++) put_item(amps_pkg::OpAck, 16'(i), 32'd200);
  endtask

  initial begin
    logic [31:0] phase_set[NumPhases];
    phase_set = '{32'hFFFF_FFFF, 32'd0, $urandom, 32'd50000, 32'hFFFF_FFFF, 32'h8000_0000};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int p = 0; p < NumPhases; p++) begin
      calm = (p == 3);
      write_reg(amps_pkg::RegMaxOut, 32'(KmaxSet[p]));
      write_reg(amps_pkg::RegPhase, phase_set[p]);
      write_reg(amps_pkg::RegMargin, 32'(MarginSet[p]));
      write_reg(amps_pkg::RegInitRtt, InitSet[p]);
      write_reg(amps_pkg::RegRunLen, 32'(RunSet[p]));
      cfg_valid <= 1'b0;
      if (p == 0) directed_items();
      repeat (205) random_item();
      drain();
    end
    repeat (60) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
